>>> hdl/ppt_pkg.sv
// Shared types, constants and register codes of the predominant period tracker.
package ppt_pkg;

    // Sample width limits and default
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAG_W           = 32;

    // Configuration port layout
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE_HZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN     = 3'd4;

    // Register reset values
    localparam logic [23:0] RST_INPUT_GAIN     = 24'd65536;
    localparam logic [31:0] RST_ENERGY_DECAY   = 32'd4262110796;
    localparam logic [31:0] RST_NOISE_RATE     = 32'd988836;
    localparam logic [9:0]  RST_SAMPLE_RATE_HZ = 10'd100;
    localparam logic [31:0] RST_NOISE_GAIN     = 32'd65536;

    // Arithmetic constants: 0.001 in Q0.24, 2*pi in Q3.29
    localparam logic [31:0] MEAN_COEF_Q24 = 32'd16777;
    localparam logic [31:0] TWO_PI_Q29    = 32'd3373259426;

    // Configuration register set
    typedef struct packed {
        logic [23:0] input_gain;
        logic [31:0] energy_decay;
        logic [31:0] noise_rate;
        logic [9:0]  sample_rate_hz;
        logic [31:0] noise_gain;
    } ppt_cfg_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } ppt_item_t;

endpackage

>>> hdl/ppt_front.sv
// Front end: accept samples, split them into sign and magnitude, queue them.
module ppt_front #(
    parameter int SAMPLE_BITS = ppt_pkg::SAMPLE_BITS_DEF,
    parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // sample_value
    output logic              item_valid,
    output ppt_pkg::ppt_item_t item,
    input  logic              item_pop
);

    ppt_pkg::ppt_item_t   queue_mem [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS:0] mag_w;
    ppt_pkg::ppt_item_t   in_item;
    logic                 push;
    logic                 pop;

    // Classify the incoming sample
    always_comb
    begin
        raw   = s_tdata[SAMPLE_BITS-1:0];
        mag_w = raw[SAMPLE_BITS-1] ? -{raw[SAMPLE_BITS-1], raw} : {1'b0, raw};
        in_item.neg = raw[SAMPLE_BITS-1];
        in_item.mag = ppt_pkg::MAG_W'(mag_w[SAMPLE_BITS-1:0]);
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_mem[rd_ptr_reg];

    // Hold the queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> hdl/ppt_back.sv
// Back end: sequenced filter, energy, divide and square root datapath.
module ppt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ppt_pkg::ppt_cfg_t  cfg,
    input  logic               item_valid,
    input  ppt_pkg::ppt_item_t item,
    output logic               item_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // period_value
    output logic [0:0]         m_tuser    // period_saturated
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_X, ST_D, ST_DIFF, ST_M0, ST_M1, ST_M2, ST_C, ST_R,
        ST_R0, ST_R1, ST_R2, ST_SX, ST_SD, ST_XA, ST_XB, ST_DA, ST_DB,
        ST_NA, ST_NB, ST_NC, ST_GA, ST_GB, ST_GC, ST_DEN, ST_CHK,
        ST_DIV, ST_SQI, ST_SQ, ST_P, ST_P2, ST_OUT
    } state_t;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    state_t             state_reg;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_reg;
    logic [63:0]        tmp_reg;
    logic               s_neg_reg;
    logic [31:0]        s_mag_reg;
    logic signed [47:0] x_reg;
    logic signed [47:0] mean_reg;
    logic signed [47:0] prev_reg;
    logic signed [47:0] c_reg;
    logic               d_neg_reg;
    logic [48:0]        d_mag_reg;
    logic [48:0]        dr_mag_reg;
    logic [30:0]        mq_c_reg;
    logic [30:0]        mq_r_reg;
    logic [63:0]        sx_reg;
    logic [63:0]        sd_reg;
    logic [63:0]        sig_e_reg;
    logic [63:0]        der_e_reg;
    logic [63:0]        noise_reg;
    logic [63:0]        nd_reg;
    logic               nup_reg;
    logic [63:0]        scale_reg;
    logic [63:0]        den_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        num_reg;
    logic [63:0]        quo_reg;
    logic [63:0]        sq_v_reg;
    logic [63:0]        root_reg;
    logic [63:0]        sq_bit_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        res_period_reg;
    logic               res_sat_reg;
    logic [31:0]        period_reg;
    logic               sat_reg;
    logic               out_valid_reg;

    logic signed [56:0] x_wide;
    logic signed [47:0] x_clamp;
    logic signed [48:0] d_wide;
    logic [96:0]        step_sum;
    logic [47:0]        step_val;
    logic signed [48:0] c_wide;
    logic signed [47:0] c_clamp;
    logic signed [48:0] dr_wide;
    logic [47:0]        c_mag;
    logic [48:0]        c_round;
    logic [30:0]        mq_c;
    logic [63:0]        r_mag;
    logic [64:0]        r_round;
    logic [30:0]        mq_r;
    logic [63:0]        mq32;
    logic [64:0]        scale_sum;
    logic [63:0]        scale_val;
    logic [64:0]        div_t;
    logic               div_ge;
    logic [64:0]        div_diff;
    logic [63:0]        sq_sum;
    logic [64:0]        p_sum;

    // Saturating 64-bit add
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction

    // Select the shared multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_X:
            begin
                mul_a = s_mag_reg;
                mul_b = 32'(cfg.input_gain);
            end
            ST_M0:
            begin
                mul_a = d_mag_reg[31:0];
                mul_b = ppt_pkg::MEAN_COEF_Q24;
            end
            ST_M1:
            begin
                mul_a = 32'(d_mag_reg[48:32]);
                mul_b = ppt_pkg::MEAN_COEF_Q24;
            end
            ST_R0:
            begin
                mul_a = dr_mag_reg[31:0];
                mul_b = 32'(cfg.sample_rate_hz);
            end
            ST_R1:
            begin
                mul_a = 32'(dr_mag_reg[48:32]);
                mul_b = 32'(cfg.sample_rate_hz);
            end
            ST_R2:
            begin
                mul_a = 32'(mq_c_reg);
                mul_b = 32'(mq_c_reg);
            end
            ST_SX:
            begin
                mul_a = 32'(mq_r_reg);
                mul_b = 32'(mq_r_reg);
            end
            ST_SD:
            begin
                mul_a = sig_e_reg[63:32];
                mul_b = cfg.energy_decay;
            end
            ST_XA:
            begin
                mul_a = sig_e_reg[31:0];
                mul_b = cfg.energy_decay;
            end
            ST_XB:
            begin
                mul_a = der_e_reg[63:32];
                mul_b = cfg.energy_decay;
            end
            ST_DA:
            begin
                mul_a = der_e_reg[31:0];
                mul_b = cfg.energy_decay;
            end
            ST_NA:
            begin
                mul_a = nd_reg[63:32];
                mul_b = cfg.noise_rate;
            end
            ST_NB:
            begin
                mul_a = nd_reg[31:0];
                mul_b = cfg.noise_rate;
            end
            ST_GA:
            begin
                mul_a = noise_reg[63:32];
                mul_b = cfg.noise_gain;
            end
            ST_GB:
            begin
                mul_a = noise_reg[31:0];
                mul_b = cfg.noise_gain;
            end
            ST_P:
            begin
                mul_a = root_reg[31:0];
                mul_b = ppt_pkg::TWO_PI_Q29;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Datapath helpers for the individual steps
    always_comb
    begin
        // scaled sample, clamped to 48 bits
        x_wide = $signed({1'b0, prod_reg[55:0]});
        if (s_neg_reg)
        begin
            x_wide = -x_wide;
        end
        if (x_wide[56:47] != {10{x_wide[56]}})
        begin
            x_clamp = x_wide[56] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            x_clamp = x_wide[47:0];
        end

        d_wide = {x_reg[47], x_reg} - {mean_reg[47], mean_reg};

        // rounded mean step from the two partial products
        step_sum = {1'b0, prod_reg, 32'd0} + {33'd0, tmp_reg} + 97'(1 << 23);
        step_val = step_sum[71:24];

        c_wide = {x_reg[47], x_reg} - {mean_reg[47], mean_reg};
        if (c_wide[48] != c_wide[47])
        begin
            c_clamp = c_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            c_clamp = c_wide[47:0];
        end

        dr_wide = {c_reg[47], c_reg} - {prev_reg[47], prev_reg};

        // Q.4 magnitude of the centered sample
        c_mag   = c_reg[47] ? 48'(-c_reg) : 48'(c_reg);
        c_round = ({1'b0, c_mag} + 49'd2048) >> 12;
        mq_c    = (c_round[48:31] != 18'd0) ? {31{1'b1}} : c_round[30:0];

        // Q.4 magnitude of the derivative
        r_mag   = {prod_reg[31:0], 32'd0} + tmp_reg;
        r_round = ({1'b0, r_mag} + 65'd2048) >> 12;
        mq_r    = (r_round[64:31] != 34'd0) ? {31{1'b1}} : r_round[30:0];

        // high partial plus high half of low partial
        mq32 = tmp_reg + {32'd0, prod_reg[63:32]};

        scale_sum = {1'b0, tmp_reg[47:0], 16'd0} + {17'd0, prod_reg[63:16]};
        if (tmp_reg[63:48] != 16'd0 || scale_sum[64])
        begin
            scale_val = ALL_ONES;
        end
        else
        begin
            scale_val = scale_sum[63:0];
        end

        // one restoring division step
        div_t    = {rem_reg, num_reg[63]};
        div_ge   = (div_t >= {1'b0, den_reg});
        div_diff = div_t - {1'b0, den_reg};

        sq_sum = root_reg + sq_bit_reg;

        p_sum = {1'b0, prod_reg} + 65'(1 << 28);
    end

    assign item_pop = (state_reg == ST_IDLE) && item_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = period_reg;
    assign m_tuser  = sat_reg;

    // Hold filter state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mean_reg      <= '0;
            prev_reg      <= '0;
            sig_e_reg     <= '0;
            der_e_reg     <= '0;
            noise_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            // load a finished result or drop the one just taken
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        s_neg_reg <= item.neg;
                        s_mag_reg <= item.mag;
                        state_reg <= ST_X;
                    end
                end
                ST_X:
                begin
                    state_reg <= ST_D;
                end
                ST_D:
                begin
                    x_reg     <= x_clamp;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    d_neg_reg <= d_wide[48];
                    d_mag_reg <= d_wide[48] ? 49'(-d_wide) : 49'(d_wide);
                    state_reg <= ST_M0;
                end
                ST_M0:
                begin
                    state_reg <= ST_M1;
                end
                ST_M1:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    mean_reg  <= d_neg_reg ? mean_reg - $signed(step_val)
                                           : mean_reg + $signed(step_val);
                    state_reg <= ST_C;
                end
                ST_C:
                begin
                    c_reg     <= c_clamp;
                    state_reg <= ST_R;
                end
                ST_R:
                begin
                    dr_mag_reg <= dr_wide[48] ? 49'(-dr_wide) : 49'(dr_wide);
                    prev_reg   <= c_reg;
                    mq_c_reg   <= mq_c;
                    state_reg  <= ST_R0;
                end
                ST_R0:
                begin
                    state_reg <= ST_R1;
                end
                ST_R1:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_R2;
                end
                ST_R2:
                begin
                    mq_r_reg  <= mq_r;
                    state_reg <= ST_SX;
                end
                ST_SX:
                begin
                    sx_reg    <= prod_reg;
                    state_reg <= ST_SD;
                end
                ST_SD:
                begin
                    sd_reg    <= prod_reg;
                    state_reg <= ST_XA;
                end
                ST_XA:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_XB;
                end
                ST_XB:
                begin
                    sig_e_reg <= sat_add(mq32, sx_reg);
                    state_reg <= ST_DA;
                end
                ST_DA:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_DB;
                end
                ST_DB:
                begin
                    der_e_reg <= sat_add(mq32, sd_reg);
                    nup_reg   <= (sx_reg >= noise_reg);
                    nd_reg    <= (sx_reg >= noise_reg) ? sx_reg - noise_reg
                                                       : noise_reg - sx_reg;
                    state_reg <= ST_NA;
                end
                ST_NA:
                begin
                    state_reg <= ST_NB;
                end
                ST_NB:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_NC;
                end
                ST_NC:
                begin
                    noise_reg <= nup_reg ? noise_reg + mq32 : noise_reg - mq32;
                    state_reg <= ST_GA;
                end
                ST_GA:
                begin
                    state_reg <= ST_GB;
                end
                ST_GB:
                begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_GC;
                end
                ST_GC:
                begin
                    scale_reg <= scale_val;
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    den_reg   <= sat_add(der_e_reg, scale_reg);
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    // zero divisor or oversized quotient saturates at once
                    if (den_reg == 64'd0 || {32'd0, sig_e_reg[63:32]} >= den_reg)
                    begin
                        res_period_reg <= 32'hFFFF_FFFF;
                        res_sat_reg    <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        rem_reg   <= {32'd0, sig_e_reg[63:32]};
                        num_reg   <= {sig_e_reg[31:0], 32'd0};
                        quo_reg   <= 64'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= div_ge ? div_diff[63:0] : div_t[63:0];
                    quo_reg <= {quo_reg[62:0], div_ge};
                    num_reg <= {num_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= ST_SQI;
                    end
                end
                ST_SQI:
                begin
                    sq_v_reg   <= quo_reg;
                    root_reg   <= 64'd0;
                    sq_bit_reg <= 64'd1 << 62;
                    cnt_reg    <= 6'd0;
                    state_reg  <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (sq_v_reg >= sq_sum)
                    begin
                        sq_v_reg <= sq_v_reg - sq_sum;
                        root_reg <= (root_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= ST_P;
                    end
                end
                ST_P:
                begin
                    state_reg <= ST_P2;
                end
                ST_P2:
                begin
                    if (p_sum[64:61] == 4'd0)
                    begin
                        res_period_reg <= p_sum[60:29];
                        res_sat_reg    <= 1'b0;
                    end
                    else
                    begin
                        res_period_reg <= 32'hFFFF_FFFF;
                        res_sat_reg    <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // wait until the output register is free, then load it
                    if (!out_valid_reg || m_tready)
                    begin
                        period_reg <= res_period_reg;
                        sat_reg    <= res_sat_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("division remainder not below divisor");

    // Divide path is entered only with a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != 64'd0)
        else $error("division started with zero divisor");

    // Root of a 64-bit quotient fits in 32 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_P |-> root_reg[63:32] == 32'd0)
        else $error("square root wider than 32 bits");

    // A finished result is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid_reg || m_tready)) |=> out_valid_reg)
        else $error("result not presented");

    // No new sample is taken unless the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> state_reg == ST_IDLE)
        else $error("sample popped while busy");

endmodule

>>> hdl/predominant_period_tracker.sv
// Top level of the predominant period tracker: configuration registers and hookup.
//
// Each input sample passes from acceptance to result through the mean filter, the energy
// updates and the divisor, all sharing one 32x32 multiplier, then the one-bit-per-cycle
// restoring divider and the two-bit-per-cycle square root. A sample whose divisor is zero
// or whose quotient overflows skips the divider and root. A two-entry queue ahead of the
// sequencer accepts samples while one is being processed, and the result register holds
// a finished period while the next sample already runs.
module predominant_period_tracker #(
    parameter int SAMPLE_BITS = ppt_pkg::SAMPLE_BITS_DEF,
    parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,   // sample_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // period_value
    output logic [0:0]                     m_tuser    // period_saturated
);

    ppt_pkg::ppt_cfg_t  cfg_reg;
    ppt_pkg::ppt_item_t item;
    logic               item_valid;
    logic               item_pop;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_gain     <= ppt_pkg::RST_INPUT_GAIN;
            cfg_reg.energy_decay   <= ppt_pkg::RST_ENERGY_DECAY;
            cfg_reg.noise_rate     <= ppt_pkg::RST_NOISE_RATE;
            cfg_reg.sample_rate_hz <= ppt_pkg::RST_SAMPLE_RATE_HZ;
            cfg_reg.noise_gain     <= ppt_pkg::RST_NOISE_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppt_pkg::CFG_INPUT_GAIN:     cfg_reg.input_gain     <= cfg_data[23:0];
                ppt_pkg::CFG_ENERGY_DECAY:   cfg_reg.energy_decay   <= cfg_data;
                ppt_pkg::CFG_NOISE_RATE:     cfg_reg.noise_rate     <= cfg_data;
                ppt_pkg::CFG_SAMPLE_RATE_HZ: cfg_reg.sample_rate_hz <= cfg_data[9:0];
                ppt_pkg::CFG_NOISE_GAIN:     cfg_reg.noise_gain     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ppt_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    ppt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
